@@ rtl/core/adtp_pkg.sv @@
// ----------------------------------------------------------------------------
// adtp_pkg
// Shared types and constants for the affinity deadline task picker.
// ----------------------------------------------------------------------------
package adtp_pkg;

  localparam int unsigned SLOTS   = 64;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned USER_W  = 10;
  localparam int unsigned EXE_W   = 16;
  localparam int unsigned DL_W    = 20;
  localparam int unsigned ELAP_W  = 32;
  localparam int unsigned CUR_W   = TYPE_W + 1;
  localparam int unsigned RANK_W  = 3;

  localparam logic [CUR_W-1:0] NO_TYPE = '1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_INS_SCAN,
    FSM_POP_SCAN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [TYPE_W-1:0] msg_type;
    logic [USER_W-1:0] user_id;
    logic [EXE_W-1:0]  exe_time;
    logic [DL_W-1:0]   deadline;
    logic              late;
  } task_t;

endpackage

@@ rtl/core/affinity_deadline_task_picker_top.sv @@
// ----------------------------------------------------------------------------
// affinity_deadline_task_picker_top
// Earliest-deadline-first task store with type affinity, one slot memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o      | operation + task fields
//  out     | output    | out_valid_o / out_stall_i    | status + popped task
//  cfg     | input     | cfg_valid_i / cfg_ready_o    | deadline_horizon (20 b)
//
//  One word at a time; every slot read goes through the single read port.
//  Pop: one read per slot, then the last compare, the commit and the output
//  load. Insert: the walk runs until a free slot turns up or every slot is
//  seen busy, which gives a full result.
//  Reset clears valid bits, elapsed time and current type; slot data is kept.
//  A stalled output holds back the next result's hand-over and the next input word.
//
module affinity_deadline_task_picker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [adtp_pkg::TYPE_W-1:0] msg_type_i,
  input  logic [adtp_pkg::USER_W-1:0] user_id_i,
  input  logic [adtp_pkg::EXE_W-1:0]  exe_time_i,
  input  logic [adtp_pkg::DL_W-1:0]   deadline_i,
  input  logic                        late_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [adtp_pkg::TYPE_W-1:0] out_type_o,
  output logic [adtp_pkg::USER_W-1:0] out_user_o,
  output logic [adtp_pkg::EXE_W-1:0]  out_exe_time_o,
  output logic [adtp_pkg::DL_W-1:0]   out_deadline_o,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [adtp_pkg::DL_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W = adtp_pkg::IDX_W;
  localparam int unsigned CNT_W = adtp_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  adtp_pkg::fsm_e                  state_q, state_d;

  logic [adtp_pkg::DL_W-1:0]       horizon_q;
  logic [adtp_pkg::SLOTS-1:0]      valid_q;
  logic [adtp_pkg::ELAP_W-1:0]     elapsed_q;
  logic [adtp_pkg::CUR_W-1:0]      cur_type_q;

  // captured input word (deadline already clamped)
  adtp_pkg::task_t                 in_task_q;

  // scan
  logic [CNT_W-1:0]                scan_cnt_q;
  logic                            rd_vld_q;
  logic                            rd_ok_q;
  logic [IDX_W-1:0]                rd_idx_q;
  adtp_pkg::task_t                 rd_data_q;

  // best candidate so far
  logic                            best_found_q;
  logic [adtp_pkg::RANK_W-1:0]     best_rank_q;
  logic [IDX_W-1:0]                best_idx_q;
  adtp_pkg::task_t                 best_task_q;

  // pending result
  adtp_pkg::status_e               res_status_q;
  adtp_pkg::task_t                 res_task_q;

  // output register
  logic                            out_valid_q;
  adtp_pkg::status_e               out_status_q;
  adtp_pkg::task_t                 out_task_q;

  adtp_pkg::task_t                 slot_mem [adtp_pkg::SLOTS];

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                            in_fire;
  logic                            out_free;
  logic                            scan_left;
  logic [IDX_W-1:0]                scan_idx;
  logic                            slot_free;
  logic                            scan_end;
  logic [adtp_pkg::DL_W-1:0]       dl_clamped;

  logic [adtp_pkg::ELAP_W:0]       cand_limit;
  logic [adtp_pkg::RANK_W-1:0]     cand_rank;
  logic                            cand_better;
  logic [adtp_pkg::ELAP_W:0]       elap_sum;
  logic [adtp_pkg::ELAP_W-1:0]     elap_next;

  // control strobes
  logic                            ctl_issue;
  logic                            ctl_ins_write;
  logic                            ctl_ins_full;
  logic                            ctl_pop_commit;
  logic                            ctl_out_load;

  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign scan_left   = scan_cnt_q < CNT_W'(adtp_pkg::SLOTS);
  assign scan_idx    = scan_cnt_q[IDX_W-1:0];
  assign slot_free   = ~valid_q[scan_idx];
  assign scan_end    = ~scan_left & ~rd_vld_q;
  assign dl_clamped  = (deadline_i > horizon_q) ? horizon_q : deadline_i;

  // key levels: type mismatch, late, not urgent (lower rank is better)
  assign cand_limit  = {1'b0, elapsed_q} + (adtp_pkg::ELAP_W + 1)'(rd_data_q.exe_time);
  assign cand_rank   = {({1'b0, rd_data_q.msg_type} != cur_type_q),
                        rd_data_q.late,
                        ~((adtp_pkg::ELAP_W + 1)'(rd_data_q.deadline) <= cand_limit)};
  assign cand_better = rd_vld_q & rd_ok_q &
                       (~best_found_q || (cand_rank < best_rank_q) ||
                        ((cand_rank == best_rank_q) &&
                         (rd_data_q.deadline < best_task_q.deadline)));

  // saturating elapsed-time update
  assign elap_sum    = {1'b0, elapsed_q} + (adtp_pkg::ELAP_W + 1)'(best_task_q.exe_time);
  assign elap_next   = elap_sum[adtp_pkg::ELAP_W] ? '1 : elap_sum[adtp_pkg::ELAP_W-1:0];

  // --------------------------------------------------------------------------
  // FSM: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      adtp_pkg::FSM_IDLE: begin
        if (in_fire) begin
          state_d = (operation_i == adtp_pkg::OP_POP) ? adtp_pkg::FSM_POP_SCAN
                                                      : adtp_pkg::FSM_INS_SCAN;
        end
      end
      adtp_pkg::FSM_INS_SCAN: begin
        if (!scan_left || slot_free) state_d = adtp_pkg::FSM_DONE;
      end
      adtp_pkg::FSM_POP_SCAN: begin
        if (scan_end) state_d = adtp_pkg::FSM_DONE;
      end
      adtp_pkg::FSM_DONE: begin
        if (out_free) state_d = adtp_pkg::FSM_IDLE;
      end
      default: state_d = adtp_pkg::FSM_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // FSM: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o     = 1'b1;
    ctl_issue      = 1'b0;
    ctl_ins_write  = 1'b0;
    ctl_ins_full   = 1'b0;
    ctl_pop_commit = 1'b0;
    ctl_out_load   = 1'b0;
    case (state_q)
      adtp_pkg::FSM_IDLE: begin
        in_stall_o = 1'b0;
      end
      adtp_pkg::FSM_INS_SCAN: begin
        ctl_ins_write = scan_left & slot_free;
        ctl_ins_full  = ~scan_left;
      end
      adtp_pkg::FSM_POP_SCAN: begin
        ctl_issue      = scan_left;
        ctl_pop_commit = scan_end;
      end
      adtp_pkg::FSM_DONE: begin
        ctl_out_load = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Slot memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ctl_ins_write) slot_mem[scan_idx] <= in_task_q;
    rd_data_q <= slot_mem[scan_idx];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= adtp_pkg::FSM_IDLE;
      horizon_q    <= '1;
      valid_q      <= '0;
      elapsed_q    <= '0;
      cur_type_q   <= adtp_pkg::NO_TYPE;
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) horizon_q <= cfg_data_i;

      if (in_fire) begin
        scan_cnt_q   <= '0;
        best_found_q <= 1'b0;
      end else if (ctl_issue || (state_q == adtp_pkg::FSM_INS_SCAN && scan_left)) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      end

      rd_vld_q <= ctl_issue;

      if (cand_better) best_found_q <= 1'b1;

      if (ctl_ins_write) valid_q[scan_idx] <= 1'b1;

      if (ctl_pop_commit && best_found_q) begin
        valid_q[best_idx_q] <= 1'b0;
        elapsed_q           <= elap_next;
        cur_type_q          <= {1'b0, best_task_q.msg_type};
      end

      if (ctl_out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_task_q.msg_type <= msg_type_i;
      in_task_q.user_id  <= user_id_i;
      in_task_q.exe_time <= exe_time_i;
      in_task_q.deadline <= dl_clamped;
      in_task_q.late     <= late_i;
    end

    rd_ok_q  <= valid_q[scan_idx];
    rd_idx_q <= scan_idx;

    if (cand_better) begin
      best_rank_q <= cand_rank;
      best_idx_q  <= rd_idx_q;
      best_task_q <= rd_data_q;
    end

    if (ctl_ins_write) begin
      res_status_q <= adtp_pkg::ST_INSERTED;
      res_task_q   <= '0;
    end else if (ctl_ins_full) begin
      res_status_q <= adtp_pkg::ST_FULL;
      res_task_q   <= '0;
    end else if (ctl_pop_commit) begin
      res_status_q <= best_found_q ? adtp_pkg::ST_POPPED : adtp_pkg::ST_EMPTY;
      res_task_q   <= best_found_q ? best_task_q : '0;
    end

    if (ctl_out_load) begin
      out_status_q <= res_status_q;
      out_task_q   <= res_task_q;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_type_o     = out_task_q.msg_type;
  assign out_user_o     = out_task_q.user_id;
  assign out_exe_time_o = out_task_q.exe_time;
  assign out_deadline_o = out_task_q.deadline;

`ifndef ASSERT_OFF
  // the best candidate always points at a live slot during a pop walk
  a_best_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adtp_pkg::FSM_POP_SCAN && best_found_q) |-> valid_q[best_idx_q])
    else $error("best candidate slot not valid");

  // a committed pop frees the chosen slot
  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_pop_commit && best_found_q) |=> !valid_q[$past(best_idx_q)])
    else $error("popped slot still valid");

  // elapsed time only grows
  a_elapsed_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> elapsed_q >= $past(elapsed_q))
    else $error("elapsed time went backwards");

  // the walk never runs past the last slot
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cnt_q <= CNT_W'(adtp_pkg::SLOTS))
    else $error("scan counter out of range");

  // a result is only loaded when the output register can take it
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while stalled");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the affinity deadline task picker. Words are pushed
// in over the stall handshake and each is run through a behavioural pick
// model at the moment it is accepted. Every result word is compared field by
// field with the oldest prediction. The run covers directed corner cases,
// random insert/pop traffic under several horizon settings and idle
// patterns, a full store under long output back-pressure, and elapsed time
// grown beyond every possible deadline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SLOTS  = adtp_pkg::SLOTS;
  localparam int unsigned TYPE_W = adtp_pkg::TYPE_W;
  localparam int unsigned USER_W = adtp_pkg::USER_W;
  localparam int unsigned EXE_W  = adtp_pkg::EXE_W;
  localparam int unsigned DL_W   = adtp_pkg::DL_W;
  localparam int unsigned ELAP_W = adtp_pkg::ELAP_W;
  localparam int unsigned CUR_W  = adtp_pkg::CUR_W;
  localparam int unsigned RANK_W = adtp_pkg::RANK_W;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = SLOTS + 8;
  localparam int unsigned MAX_REPORTS   = 10;

  // one result word as the block presents it
  typedef struct packed {
    adtp_pkg::status_e status;
    logic [TYPE_W-1:0] msg_type;
    logic [USER_W-1:0] user_id;
    logic [EXE_W-1:0]  exe_time;
    logic [DL_W-1:0]   deadline;
  } outcome_t;

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              operation_i = 1'b0;
  logic [TYPE_W-1:0] msg_type_i  = '0;
  logic [USER_W-1:0] user_id_i   = '0;
  logic [EXE_W-1:0]  exe_time_i  = '0;
  logic [DL_W-1:0]   deadline_i  = '0;
  logic              late_i      = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [TYPE_W-1:0] out_type_o;
  logic [USER_W-1:0] out_user_o;
  logic [EXE_W-1:0]  out_exe_time_o;
  logic [DL_W-1:0]   out_deadline_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [DL_W-1:0]   cfg_data_i  = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  affinity_deadline_task_picker_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .msg_type_i     (msg_type_i),
    .user_id_i      (user_id_i),
    .exe_time_i     (exe_time_i),
    .deadline_i     (deadline_i),
    .late_i         (late_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_type_o     (out_type_o),
    .out_user_o     (out_user_o),
    .out_exe_time_o (out_exe_time_o),
    .out_deadline_o (out_deadline_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // pick model state: a shadow of the slot store, current type, elapsed time
  // and the horizon register, updated as each word is accepted
  // --------------------------------------------------------------------------
  logic              slot_busy [SLOTS] = '{default: 1'b0};
  adtp_pkg::task_t   slot_word [SLOTS];
  logic [CUR_W-1:0]  cur_type   = adtp_pkg::NO_TYPE;
  logic [ELAP_W-1:0] elapsed    = '0;
  logic [DL_W-1:0]   horizon    = '1;
  int unsigned       slots_used = 0;

  outcome_t          outcomes_due [$];     // predictions awaiting their result

  // stimulus knobs and tallies
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_stall_pct = 0;
  logic              rx_hold      = 1'b0;
  logic [TYPE_W-1:0] type_pool [4];
  int unsigned       n_stored = 0, n_dropped = 0, n_picked = 0, n_empty = 0;
  int unsigned       n_horizon_writes = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  // Applies one accepted word to the shadow store and returns the word the
  // block must answer with. Pick key, best first: affinity to the current
  // type, not late, urgent, earlier deadline, lower slot.
  function automatic outcome_t store_outcome(adtp_pkg::op_e op, adtp_pkg::task_t word);
    outcome_t          res;
    int                best;
    int                i;
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] best_rank;
    logic [DL_W-1:0]   best_dl;
    logic [ELAP_W:0]   reach;
    res       = '0;
    best      = -1;
    best_rank = '0;
    best_dl   = '0;
    if (op == adtp_pkg::OP_INSERT) begin
      res.status = adtp_pkg::ST_INSERTED;
      if (word.deadline > horizon) word.deadline = horizon;
      // lowest free slot
      for (i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_busy[i]) best = i;
      end
      if (best < 0) begin
        res.status = adtp_pkg::ST_FULL;
        n_dropped++;
      end else begin
        slot_busy[best] = 1'b1;
        slot_word[best] = word;
        slots_used++;
        n_stored++;
      end
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_busy[i]) begin
          // 33-bit sum so urgency never wraps
          reach = {1'b0, elapsed} + (ELAP_W + 1)'(slot_word[i].exe_time);
          rank  = {({1'b0, slot_word[i].msg_type} != cur_type),
                   slot_word[i].late,
                   ((ELAP_W + 1)'(slot_word[i].deadline) > reach)};
          if (best < 0 || rank < best_rank ||
              (rank == best_rank && slot_word[i].deadline < best_dl)) begin
            best      = i;
            best_rank = rank;
            best_dl   = slot_word[i].deadline;
          end
        end
      end
      if (best < 0) begin
        res.status = adtp_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        res.status   = adtp_pkg::ST_POPPED;
        res.msg_type = slot_word[best].msg_type;
        res.user_id  = slot_word[best].user_id;
        res.exe_time = slot_word[best].exe_time;
        res.deadline = slot_word[best].deadline;
        reach        = {1'b0, elapsed} + (ELAP_W + 1)'(slot_word[best].exe_time);
        elapsed      = reach[ELAP_W] ? '1 : reach[ELAP_W-1:0];   // saturates
        cur_type     = {1'b0, slot_word[best].msg_type};
        slot_busy[best] = 1'b0;
        slots_used--;
        n_picked++;
      end
    end
    return res;
  endfunction

  function automatic adtp_pkg::task_t task_word(logic [TYPE_W-1:0] msg_type,
                                                logic [USER_W-1:0] user_id,
                                                logic [EXE_W-1:0] exe_time,
                                                logic [DL_W-1:0] deadline, logic late);
    return '{msg_type, user_id, exe_time, deadline, late};
  endfunction

  // Random task: types mostly from a small pool so affinity matters, short
  // run times so elapsed time grows slowly, deadlines mostly close to the
  // elapsed time so urgency flips both ways. Full-range values now and then.
  function automatic adtp_pkg::task_t random_task();
    adtp_pkg::task_t word;
    longint          dl;
    if ($urandom_range(9) == 0) word.msg_type = TYPE_W'($urandom_range(255));
    else                        word.msg_type = type_pool[$urandom_range(3)];
    word.user_id = USER_W'($urandom_range(2**USER_W - 1));
    if ($urandom_range(6) == 0) word.exe_time = EXE_W'($urandom_range(2**EXE_W - 1));
    else                        word.exe_time = EXE_W'($urandom_range(255));
    dl = longint'(elapsed) + longint'($urandom_range(600)) - longint'(300);
    if ($urandom_range(4) == 0) dl = longint'($urandom_range(2**DL_W - 1));
    if (dl < 0)                 word.deadline = '0;
    else if (dl > 2**DL_W - 1)  word.deadline = '1;
    else                        word.deadline = dl[DL_W-1:0];
    word.late = 1'($urandom_range(1));
    return word;
  endfunction

  task automatic refresh_type_pool();
    foreach (type_pool[k]) type_pool[k] = TYPE_W'($urandom_range(255));
  endtask

  // --------------------------------------------------------------------------
  // input side: one word per call, optional idle gap first; valid stays high
  // into the next call unless that call idles
  // --------------------------------------------------------------------------
  task automatic send_word(adtp_pkg::op_e op, adtp_pkg::task_t word);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    msg_type_i  <= word.msg_type;
    user_id_i   <= word.user_id;
    exe_time_i  <= word.exe_time;
    deadline_i  <= word.deadline;
    late_i      <= word.late;
    do @(posedge clk); while (in_stall_o);
    outcomes_due.insert(outcomes_due.size(), store_outcome(op, word));
  endtask

  // horizon is only written with the block idle and every result home
  task automatic set_horizon(logic [DL_W-1:0] value);
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    horizon = value;
    n_horizon_writes++;
  endtask

  // --------------------------------------------------------------------------
  // output side: random stall plus the long hold-off, and the result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, out_type_o, out_user_o, out_exe_time_o, out_deadline_o};
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0d] result word with nothing expected: status %0d type %0h user %0h",
                   cycles, got.status, got.msg_type, got.user_id);
      end else begin
        want = outcomes_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0d] mismatch: expected status %0d type %0h user %0h exe %0h dl %0h",
                     cycles, want.status, want.msg_type, want.user_id, want.exe_time,
                     want.deadline);
            $display("[%0d]           actual   status %0d type %0h user %0h exe %0h dl %0h",
                     cycles, got.status, got.msg_type, got.user_id, got.exe_time,
                     got.deadline);
          end
        end
      end
    end
    out_stall_i <= rx_hold || (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, outcomes_due.size());
      $display("affinity_deadline_task_picker_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // Field extremes, pop on an empty store, and each level of the pick key:
  // affinity beating everything, late losing, urgency beating a smaller
  // deadline, equal deadlines going to the lower slot.
  task automatic test_directed();
    send_word(adtp_pkg::OP_POP, '0);                                 // empty store
    send_word(adtp_pkg::OP_INSERT, task_word('0, '0, '0, '0, 1'b0)); // all low
    send_word(adtp_pkg::OP_INSERT, task_word('1, '1, '1, '1, 1'b1)); // all high
    send_word(adtp_pkg::OP_POP, '0);
    send_word(adtp_pkg::OP_POP, '0);
    send_word(adtp_pkg::OP_POP, '0);                                 // empty again
    send_word(adtp_pkg::OP_INSERT, task_word(8'h07, 10'd1, 16'd0, 20'd500000, 1'b0));
    send_word(adtp_pkg::OP_INSERT, task_word(8'h09, 10'd2, 16'd0, 20'd1000, 1'b1));
    send_word(adtp_pkg::OP_INSERT, task_word(8'hff, 10'd3, 16'd4, '1, 1'b1)); // affinity only
    send_word(adtp_pkg::OP_POP, '0);
    send_word(adtp_pkg::OP_INSERT, task_word(8'h09, 10'd4, 16'd0, 20'd500000, 1'b0));
    send_word(adtp_pkg::OP_INSERT, task_word(8'h09, 10'd5, 16'd0, 20'd600000, 1'b0));
    send_word(adtp_pkg::OP_POP, '0);                                 // deadline tie
    send_word(adtp_pkg::OP_POP, '0);
    send_word(adtp_pkg::OP_POP, '0);                                 // late loses
    send_word(adtp_pkg::OP_POP, '0);
    send_word(adtp_pkg::OP_POP, '0);
    send_word(adtp_pkg::OP_INSERT, task_word(8'h01, 10'd6, 16'd60000, 20'd120000, 1'b0));
    send_word(adtp_pkg::OP_INSERT, task_word(8'h02, 10'd7, 16'd0, 20'd100000, 1'b0));
    send_word(adtp_pkg::OP_POP, '0);                                 // urgent wins
    send_word(adtp_pkg::OP_POP, '0);
  endtask

  // Mixed traffic; pop odds follow occupancy so the store swings between
  // near empty and near full, with the odd pop on an empty store.
  task automatic test_random_mix(int unsigned words);
    int unsigned pop_pct;
    refresh_type_pool();
    repeat (words) begin
      if (slots_used < 4)              pop_pct = 25;
      else if (slots_used > SLOTS - 8) pop_pct = 70;
      else                             pop_pct = 45;
      send_word(($urandom_range(99) < pop_pct) ? adtp_pkg::OP_POP : adtp_pkg::OP_INSERT,
                random_task());
    end
  endtask

  // Receiver holds off for a long stretch while inserts keep coming: the
  // output register fills, the input stalls, and the store overflows. Then
  // drain it past empty.
  task automatic test_fill_under_backpressure();
    refresh_type_pool();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (SLOTS + 2) send_word(adtp_pkg::OP_INSERT, random_task());
    repeat (SLOTS + 1) send_word(adtp_pkg::OP_POP, random_task());
  endtask

  // Long tasks push elapsed time past the deadline range so every task
  // counts as urgent from then on.
  task automatic test_elapsed_beyond_deadlines();
    while (slots_used != 0) send_word(adtp_pkg::OP_POP, random_task());
    repeat (16) begin
      send_word(adtp_pkg::OP_INSERT,
                task_word(type_pool[0], USER_W'($urandom_range(2**USER_W - 1)), '1,
                          DL_W'($urandom_range(2**DL_W - 1)), 1'($urandom_range(1))));
      send_word(adtp_pkg::OP_POP, random_task());
    end
    test_random_mix(20);
  endtask

  initial begin
    logic [ELAP_W-1:0] near;
    tx_idle_pct  = 28;
    rx_stall_pct = 57;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    set_horizon('1);
    test_random_mix(300);
    set_horizon('0);                   // every deadline clamps to zero
    test_random_mix(100);
    test_fill_under_backpressure();

    tx_idle_pct  = 57;
    rx_stall_pct = 28;
    near = elapsed + $urandom_range(2000);
    set_horizon((near > 2**DL_W - 1) ? '1 : near[DL_W-1:0]);
    test_random_mix(300);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_horizon(DL_W'(1));
    test_random_mix(100);
    set_horizon(DL_W'($urandom_range(2**DL_W - 1)));
    test_random_mix(150);
    test_elapsed_beyond_deadlines();

    // drain, then allow one full pick time for any stray result word
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d stored, %0d dropped on a full store, %0d picked, %0d empty picks",
             n_stored, n_dropped, n_picked, n_empty);
    $display("Horizon written %0d times, elapsed time %0d, %0d mismatches, %0d cycles",
             n_horizon_writes, elapsed, mismatches, cycles);
    if (mismatches == 0) begin
      $display("affinity_deadline_task_picker_top test passed");
    end else begin
      $display("affinity_deadline_task_picker_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/adtp_pkg.sv
rtl/core/affinity_deadline_task_picker_top.sv
verif/testbench.sv
